// ----- rtl/h2st_pkg.sv -----
package h2st_pkg;

   // Stream states, numbered as reported on the result channel.
   typedef enum logic [2:0] {
      ST_IDLE       = 3'd0,
      ST_RES_LOCAL  = 3'd1,
      ST_RES_REMOTE = 3'd2,
      ST_OPEN       = 3'd3,
      ST_HC_LOCAL   = 3'd4,
      ST_HC_REMOTE  = 3'd5,
      ST_CLOSED     = 3'd6
   } stream_state_type;

   // Result status codes.
   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_GOAWAY   = 3'd1,
      STAT_RESET    = 3'd2,
      STAT_REFUSED  = 3'd3,
      STAT_ILLEGAL  = 3'd4
   } status_type;

   // Item kinds.
   typedef enum logic [1:0] {
      CMD_RX_HEADER = 2'd0,
      CMD_TX_HEADER = 2'd1,
      CMD_RX_DATA   = 2'd2,
      CMD_WIN_INC   = 2'd3
   } command_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_STREAM_NUMBER = 3'd0,
      CSR_ROLE_CLIENT   = 3'd1,
      CSR_CHUNK_NOTICE  = 3'd2,
      CSR_SEND_WIN_INIT = 3'd3,
      CSR_RECV_REFILL   = 3'd4,
      CSR_RECV_LOW_MARK = 3'd5
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   // Frame types that the stream tables look at.
   localparam logic [7:0] FT_HEADERS = 8'd1;
   localparam logic [7:0] FT_PRIORITY = 8'd2;
   localparam logic [7:0] FT_RST = 8'd3;
   localparam logic [7:0] FT_PUSH = 8'd5;
   localparam logic [7:0] FT_WINUPD = 8'd8;
   localparam logic [7:0] FT_CONT = 8'd9;

   // Flag bit positions.
   localparam int FL_END_STREAM_BIT = 0;
   localparam int FL_HDRS_DONE_BIT = 2;

   // Register reset values.
   localparam logic [30:0] RST_STREAM_NUMBER = 31'd1;
   localparam logic [30:0] RST_SEND_WIN_INIT = 31'd65535;
   localparam logic [30:0] RST_RECV_REFILL = 31'h7FFF_FFFF;
   localparam logic [30:0] RST_RECV_LOW_MARK = 31'd536870911;

endpackage

// ----- rtl/h2st_ifs.sv -----
// Input channel: one frame event per transfer.
interface h2st_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [7:0]         frame_type;
   logic [7:0]         frame_flags;
   logic [31:0]        data_length;
   logic signed [31:0] window_increment;

   modport source (output valid, command, frame_type, frame_flags, data_length,
                   window_increment, input ready);
   modport sink (input valid, command, frame_type, frame_flags, data_length,
                 window_increment, output ready);
endinterface

// Result channel: one result per transfer.
interface h2st_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [2:0]         stream_state;
   logic               headers_done;
   logic               deliver_message;
   logic               message_is_response;
   logic               send_win_update;
   logic [31:0]        update_increment;
   logic signed [31:0] send_window;

   modport source (output valid, status, stream_state, headers_done, deliver_message,
                   message_is_response, send_win_update, update_increment,
                   send_window, input ready);
   modport sink (input valid, status, stream_state, headers_done, deliver_message,
                 message_is_response, send_win_update, update_increment,
                 send_window, output ready);
endinterface

// ----- rtl/http2_stream_state_tracker.sv -----
// Tracks the state of one HTTP/2 stream. Every transfer on req_chan (a received or
// sent frame header, a received DATA length, or a send-window increment) yields exactly
// one transfer on rsp_chan, carrying the status, the stream state after the event, the
// end-of-headers mark, message delivery, any receive-window update and the send window.
// The block takes one item per clock: the stream state, the mark and both windows are
// updated in the cycle of the transfer by one table lookup and 32-bit adds or
// subtracts, and the result is held in an output register, so a new item is accepted
// whenever that register is empty or being emptied. The result is registered and
// appears in the cycle after its item is taken. Configuration writes on the csr_ port are meant for idle periods;
// writing send_window_initial or recv_window_refill also reloads the matching window.
module http2_stream_state_tracker (
   input  logic                       clock,
   input  logic                       reset,
   h2st_req_if.sink                   req_chan,
   h2st_rsp_if.source                 rsp_chan,
   input  logic                       csr_we,
   input  logic [h2st_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [h2st_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import h2st_pkg::*;

   // Configuration registers. Only the parity of the stream number is ever used,
   // and the send-window initial value only matters at the moment it is written.
   logic        stream_odd_ff;
   logic        role_is_client_ff;
   logic        chunk_notice_ff;
   logic [30:0] recv_refill_ff;
   logic [30:0] recv_low_mark_ff;

   // Stream state.
   stream_state_type cur_state_ff, cur_state_in;
   logic             headers_ended_ff, headers_ended_in;
   logic [31:0]      recv_window_ff, recv_window_in;
   logic [31:0]      send_level_ff, send_level_in;

   // Result register.
   logic        rsp_valid_ff;
   status_type  status_ff, status_in;
   logic        deliver_ff, deliver_in;
   logic        is_resp_ff, is_resp_in;
   logic        upd_ff, upd_in;
   logic [31:0] upd_inc_ff, upd_inc_in;

   logic accept;
   logic eh, es;
   command_type cmd;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign cmd = command_type'(req_chan.command);
   assign eh = req_chan.frame_flags[FL_HDRS_DONE_BIT];
   assign es = req_chan.frame_flags[FL_END_STREAM_BIT];

   // Next stream state and result for the item on the input channel.
   always_comb begin
      logic [7:0]  ft;
      logic        early;
      logic [31:0] charged;
      ft = req_chan.frame_type;
      early = 1'b0;
      charged = recv_window_ff - req_chan.data_length;
      cur_state_in = cur_state_ff;
      headers_ended_in = headers_ended_ff;
      recv_window_in = recv_window_ff;
      send_level_in = send_level_ff;
      status_in = STAT_OK;
      deliver_in = 1'b0;
      upd_in = 1'b0;
      upd_inc_in = '0;
      case (cmd)
         CMD_RX_HEADER: begin
            case (cur_state_ff)
               ST_IDLE: begin
                  if (ft == FT_HEADERS) begin
                     cur_state_in = ST_OPEN;
                  end else if (ft == FT_PUSH) begin
                     cur_state_in = ST_RES_REMOTE;
                  end else begin
                     status_in = STAT_GOAWAY;
                     early = 1'b1;
                  end
                  if (!early && eh) begin
                     headers_ended_in = 1'b1;
                  end
               end
               ST_RES_LOCAL: begin
                  if (ft == FT_RST) begin
                     cur_state_in = ST_CLOSED;
                  end
               end
               ST_RES_REMOTE: begin
                  if (ft == FT_HEADERS) begin
                     cur_state_in = ST_HC_LOCAL;
                     if (eh) begin
                        headers_ended_in = 1'b1;
                     end
                  end else if (ft == FT_RST) begin
                     cur_state_in = ST_CLOSED;
                  end
               end
               ST_OPEN: begin
                  if (ft == FT_RST) begin
                     cur_state_in = ST_CLOSED;
                  end else if (ft == FT_CONT && eh) begin
                     headers_ended_in = 1'b1;
                  end
                  // End of stream is applied last, even over a reset frame.
                  if (es) begin
                     cur_state_in = ST_HC_REMOTE;
                  end
               end
               ST_HC_LOCAL: begin
                  if ((ft == FT_HEADERS || ft == FT_CONT) && eh) begin
                     headers_ended_in = 1'b1;
                  end else if (ft == FT_RST) begin
                     cur_state_in = ST_CLOSED;
                  end
                  if (es) begin
                     cur_state_in = ST_CLOSED;
                  end
               end
               ST_HC_REMOTE: begin
                  if (ft == FT_RST) begin
                     cur_state_in = ST_CLOSED;
                  end else if (ft != FT_WINUPD && ft != FT_PRIORITY) begin
                     status_in = STAT_RESET;
                     early = 1'b1;
                  end
               end
               ST_CLOSED: begin
                  if (ft != FT_PRIORITY) begin
                     status_in = STAT_REFUSED;
                     early = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            // The end-of-headers check follows the transition.
            if (!early) begin
               if (headers_ended_in) begin
                  deliver_in = chunk_notice_ff || es;
               end else if (ft != FT_CONT) begin
                  status_in = STAT_GOAWAY;
               end
            end
         end
         CMD_TX_HEADER: begin
            case (cur_state_ff)
               ST_IDLE: begin
                  if (ft == FT_HEADERS) begin
                     cur_state_in = ST_OPEN;
                     if (eh) begin
                        headers_ended_in = 1'b1;
                     end
                  end else if (ft == FT_PUSH) begin
                     cur_state_in = ST_RES_LOCAL;
                  end else begin
                     status_in = STAT_ILLEGAL;
                  end
               end
               ST_RES_LOCAL: begin
                  if (ft == FT_HEADERS) begin
                     cur_state_in = ST_HC_REMOTE;
                     if (eh) begin
                        headers_ended_in = 1'b1;
                     end
                  end else if (ft == FT_RST) begin
                     cur_state_in = ST_CLOSED;
                  end
               end
               ST_RES_REMOTE, ST_HC_LOCAL: begin
                  if (ft == FT_RST) begin
                     cur_state_in = ST_CLOSED;
                  end
               end
               ST_OPEN: begin
                  if (ft == FT_RST) begin
                     cur_state_in = ST_CLOSED;
                  end
                  if (es) begin
                     cur_state_in = ST_HC_LOCAL;
                  end
               end
               ST_HC_REMOTE: begin
                  if (ft == FT_RST || es) begin
                     cur_state_in = ST_CLOSED;
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_RX_DATA: begin
            // Charge the receive window; refill it below the low mark in early states.
            recv_window_in = charged;
            if ((cur_state_ff == ST_OPEN || cur_state_ff == ST_IDLE ||
                 cur_state_ff == ST_RES_LOCAL || cur_state_ff == ST_RES_REMOTE) &&
                charged < {1'b0, recv_low_mark_ff}) begin
               upd_in = 1'b1;
               upd_inc_in = {1'b0, recv_refill_ff} - req_chan.data_length;
               recv_window_in = {1'b0, recv_refill_ff};
            end
         end
         CMD_WIN_INC: begin
            send_level_in = send_level_ff + req_chan.window_increment;
         end
         default: begin
         end
      endcase
      // A response when the role bit equals the parity of the stream number.
      is_resp_in = deliver_in && !(role_is_client_ff ^ stream_odd_ff);
   end

   // Configuration registers and stream state.
   always_ff @(posedge clock) begin
      if (reset) begin
         stream_odd_ff <= RST_STREAM_NUMBER[0];
         role_is_client_ff <= 1'b0;
         chunk_notice_ff <= 1'b0;
         recv_refill_ff <= RST_RECV_REFILL;
         recv_low_mark_ff <= RST_RECV_LOW_MARK;
         cur_state_ff <= ST_IDLE;
         headers_ended_ff <= 1'b0;
         recv_window_ff <= {1'b0, RST_RECV_REFILL};
         send_level_ff <= {1'b0, RST_SEND_WIN_INIT};
      end else begin
         if (accept) begin
            cur_state_ff <= cur_state_in;
            headers_ended_ff <= headers_ended_in;
            recv_window_ff <= recv_window_in;
            send_level_ff <= send_level_in;
         end
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_STREAM_NUMBER: stream_odd_ff <= csr_wdata[0];
               CSR_ROLE_CLIENT: role_is_client_ff <= csr_wdata[0];
               CSR_CHUNK_NOTICE: chunk_notice_ff <= csr_wdata[0];
               CSR_SEND_WIN_INIT: begin
                  send_level_ff <= {1'b0, csr_wdata};
               end
               CSR_RECV_REFILL: begin
                  recv_refill_ff <= csr_wdata;
                  recv_window_ff <= {1'b0, csr_wdata};
               end
               CSR_RECV_LOW_MARK: recv_low_mark_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Output register: filled on every accepted item, emptied by a result transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         deliver_ff <= deliver_in;
         is_resp_ff <= is_resp_in;
         upd_ff <= upd_in;
         upd_inc_ff <= upd_inc_in;
      end
   end

   // The state fields are read from the state registers, which hold the value after the item
   // until the next accepted item or, for the send window, the next configuration write.
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.stream_state = cur_state_ff;
   assign rsp_chan.headers_done = headers_ended_ff;
   assign rsp_chan.deliver_message = deliver_ff;
   assign rsp_chan.message_is_response = is_resp_ff;
   assign rsp_chan.send_win_update = upd_ff;
   assign rsp_chan.update_increment = upd_inc_ff;
   assign rsp_chan.send_window = send_level_ff;

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import h2st_pkg::*;

   localparam int RANDOM_TOTAL = 360;
   localparam int PHASE_ITEMS = 90;
   localparam int BURST_ITEMS = 30;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_LIMIT = 1000;
   localparam int IDLE_PCT = 24;
   localparam int REPORT_LIMIT = 20;

   // Frame type and flag values that the stream tables do not name.
   localparam logic [7:0] FT_DATA = 8'd0;
   localparam logic [7:0] FLAG_END_STREAM = 8'(1 << FL_END_STREAM_BIT);
   localparam logic [7:0] FLAG_HDRS_DONE = 8'(1 << FL_HDRS_DONE_BIT);

   // Register indexes past the last register; writes to them are dropped.
   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;

   typedef struct packed {
      command_type        cmd;
      logic [7:0]         ftype;
      logic [7:0]         flags;
      logic [31:0]        length;
      logic signed [31:0] incr;
   } frame_event_t;

   typedef struct packed {
      status_type         status;
      stream_state_type   state;
      logic               headers_done;
      logic               deliver;
      logic               is_response;
      logic               win_update;
      logic [31:0]        update_incr;
      logic signed [31:0] send_window;
   } stream_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   h2st_req_if req_chan ();
   h2st_rsp_if rsp_chan ();

   http2_stream_state_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // Test control shared with the receiver.
   bit quiet_mode = 1'b0;
   int hold_requests = 0;
   int random_sent = 0;
   int mismatch_count = 0;

   // Results still owed by the block, oldest first.
   stream_result_t pending_results[$];

   // Shadow copy of the stream tracker's registers and state.
   logic [30:0]        cfg_stream_num;
   logic               cfg_client;
   logic               cfg_chunk;
   logic [31:0]        cfg_refill;
   logic [31:0]        cfg_low_mark;
   stream_state_type   stream_now;
   logic               headers_seen;
   logic [31:0]        recv_level;
   logic signed [31:0] send_level;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("mismatch in %s at %0t: got %0h, expected %0h", what, $time, got, want);
      end
      mismatch_count++;
   endtask

   function automatic void reset_tracker();
      cfg_stream_num = RST_STREAM_NUMBER;
      cfg_client = 1'b0;
      cfg_chunk = 1'b0;
      cfg_refill = {1'b0, RST_RECV_REFILL};
      cfg_low_mark = {1'b0, RST_RECV_LOW_MARK};
      stream_now = ST_IDLE;
      headers_seen = 1'b0;
      recv_level = cfg_refill;
      send_level = {1'b0, RST_SEND_WIN_INIT};
   endfunction

   // Register writes; the two window registers also reload their window.
   function automatic void apply_register_write(input logic [2:0] idx, input logic [30:0] value);
      case (idx)
         CSR_STREAM_NUMBER: cfg_stream_num = value;
         CSR_ROLE_CLIENT:   cfg_client = value[0];
         CSR_CHUNK_NOTICE:  cfg_chunk = value[0];
         CSR_SEND_WIN_INIT: begin
            send_level = {1'b0, value};
         end
         CSR_RECV_REFILL: begin
            cfg_refill = {1'b0, value};
            recv_level = {1'b0, value};
         end
         CSR_RECV_LOW_MARK: cfg_low_mark = {1'b0, value};
         default: ;
      endcase
   endfunction

   // Advances the shadow stream by one event and returns the result it must produce.
   function automatic stream_result_t track_stream_event(input frame_event_t ev);
      stream_result_t res;
      logic eh;
      logic es;
      logic settled;
      eh = ev.flags[FL_HDRS_DONE_BIT];
      es = ev.flags[FL_END_STREAM_BIT];
      settled = 1'b0;
      res = '0;
      res.status = STAT_OK;
      case (ev.cmd)
         CMD_RX_HEADER: begin
            case (stream_now)
               ST_IDLE: begin
                  if (ev.ftype == FT_HEADERS) begin
                     stream_now = ST_OPEN;
                     headers_seen |= eh;
                  end else if (ev.ftype == FT_PUSH) begin
                     stream_now = ST_RES_REMOTE;
                     headers_seen |= eh;
                  end else begin
                     res.status = STAT_GOAWAY;
                     settled = 1'b1;
                  end
               end
               ST_RES_LOCAL: begin
                  if (ev.ftype == FT_RST) stream_now = ST_CLOSED;
               end
               ST_RES_REMOTE: begin
                  if (ev.ftype == FT_HEADERS) begin
                     stream_now = ST_HC_LOCAL;
                     headers_seen |= eh;
                  end else if (ev.ftype == FT_RST) begin
                     stream_now = ST_CLOSED;
                  end
               end
               ST_OPEN: begin
                  // End of stream is applied last, so it overrides a reset.
                  if (ev.ftype == FT_RST) stream_now = ST_CLOSED;
                  else if (ev.ftype == FT_CONT && eh) headers_seen = 1'b1;
                  if (es) stream_now = ST_HC_REMOTE;
               end
               ST_HC_LOCAL: begin
                  if ((ev.ftype == FT_HEADERS || ev.ftype == FT_CONT) && eh) headers_seen = 1'b1;
                  else if (ev.ftype == FT_RST) stream_now = ST_CLOSED;
                  if (es) stream_now = ST_CLOSED;
               end
               ST_HC_REMOTE: begin
                  if (ev.ftype == FT_RST) begin
                     stream_now = ST_CLOSED;
                  end else if (ev.ftype != FT_WINUPD && ev.ftype != FT_PRIORITY) begin
                     res.status = STAT_RESET;
                     settled = 1'b1;
                  end
               end
               ST_CLOSED: begin
                  if (ev.ftype != FT_PRIORITY) begin
                     res.status = STAT_REFUSED;
                     settled = 1'b1;
                  end
               end
               default: ;
            endcase
            // Missing end of headers is checked after the transition.
            if (!settled) begin
               if (headers_seen) res.deliver = cfg_chunk || es;
               else if (ev.ftype != FT_CONT) res.status = STAT_GOAWAY;
            end
         end
         CMD_TX_HEADER: begin
            case (stream_now)
               ST_IDLE: begin
                  if (ev.ftype == FT_HEADERS) begin
                     stream_now = ST_OPEN;
                     headers_seen |= eh;
                  end else if (ev.ftype == FT_PUSH) begin
                     stream_now = ST_RES_LOCAL;
                  end else begin
                     res.status = STAT_ILLEGAL;
                  end
               end
               ST_RES_LOCAL: begin
                  if (ev.ftype == FT_HEADERS) begin
                     stream_now = ST_HC_REMOTE;
                     headers_seen |= eh;
                  end else if (ev.ftype == FT_RST) begin
                     stream_now = ST_CLOSED;
                  end
               end
               ST_RES_REMOTE, ST_HC_LOCAL: begin
                  if (ev.ftype == FT_RST) stream_now = ST_CLOSED;
               end
               ST_OPEN: begin
                  if (ev.ftype == FT_RST) stream_now = ST_CLOSED;
                  if (es) stream_now = ST_HC_LOCAL;
               end
               ST_HC_REMOTE: begin
                  if (ev.ftype == FT_RST || es) stream_now = ST_CLOSED;
               end
               default: ;
            endcase
         end
         CMD_RX_DATA: begin
            // The receive window is refilled only in the idle, open and reserved states.
            recv_level = recv_level - ev.length;
            if ((stream_now == ST_OPEN || stream_now == ST_IDLE ||
                 stream_now == ST_RES_LOCAL || stream_now == ST_RES_REMOTE) &&
                recv_level < cfg_low_mark) begin
               res.win_update = 1'b1;
               res.update_incr = cfg_refill - ev.length;
               recv_level = cfg_refill;
            end
         end
         default: send_level = send_level + ev.incr;
      endcase
      if (res.deliver) res.is_response = cfg_client ^ cfg_stream_num[0] ^ 1'b1;
      res.state = stream_now;
      res.headers_done = headers_seen;
      res.send_window = send_level;
      return res;
   endfunction

   function automatic frame_event_t make_event(input command_type cmd, input logic [7:0] ftype,
                                               input logic [7:0] flags, input logic [31:0] length,
                                               input logic [31:0] incr);
      frame_event_t ev;
      ev.cmd = cmd;
      ev.ftype = ftype;
      ev.flags = flags;
      ev.length = length;
      ev.incr = incr;
      return ev;
   endfunction

   // Random event; stream-ending frames grow more likely as the random part goes on.
   function automatic frame_event_t random_event();
      frame_event_t ev;
      int pick;
      bit ending;
      ev.length = $urandom;
      ev.incr = $urandom;
      ev.flags = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 40) ev.cmd = CMD_RX_HEADER;
      else if (pick < 75) ev.cmd = CMD_TX_HEADER;
      else if (pick < 88) ev.cmd = CMD_RX_DATA;
      else ev.cmd = CMD_WIN_INC;
      case ($urandom_range(15))
         0:       ev.ftype = FT_DATA;
         1, 2:    ev.ftype = FT_HEADERS;
         3, 4:    ev.ftype = FT_PRIORITY;
         5:       ev.ftype = FT_RST;
         6:       ev.ftype = FT_PUSH;
         7, 8:    ev.ftype = FT_WINUPD;
         9, 10, 11: ev.ftype = FT_CONT;
         default: ev.ftype = 8'($urandom_range(255));
      endcase
      ending = $urandom_range(999) < (random_sent * 25) / RANDOM_TOTAL;
      if (!ending) begin
         if (ev.ftype == FT_RST) ev.ftype = FT_PRIORITY;
         ev.flags[FL_END_STREAM_BIT] = 1'b0;
      end else if ($urandom_range(1) == 1) begin
         ev.ftype = FT_RST;
      end else begin
         ev.flags[FL_END_STREAM_BIT] = 1'b1;
      end
      if ($urandom_range(9) != 0) ev.flags[FL_HDRS_DONE_BIT] = 1'b0;
      // Data lengths: small, straddling the low mark, or anything.
      case ($urandom_range(3))
         0: ev.length = $urandom_range(2000);
         1: ev.length = recv_level - cfg_low_mark + 32'($urandom_range(4)) - 32'd2;
         default: ;
      endcase
      case ($urandom_range(3))
         0: ev.incr = $signed(32'($urandom_range(200))) - 32'sd100;
         1: begin
            case ($urandom_range(3))
               0: ev.incr = 32'h7FFF_FFFF;
               1: ev.incr = 32'h8000_0000;
               2: ev.incr = 32'hFFFF_FFFF;
               default: ev.incr = '0;
            endcase
         end
         default: ;
      endcase
      return ev;
   endfunction

   // Offers one event, with random gaps, and records its result once it is taken.
   task automatic send_item(input frame_event_t ev);
      while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.command <= ev.cmd;
      req_chan.frame_type <= ev.ftype;
      req_chan.frame_flags <= ev.flags;
      req_chan.data_length <= ev.length;
      req_chan.window_increment <= ev.incr;
      do @(posedge clock); while (!req_chan.ready);
      pending_results.push_back(track_stream_event(ev));
   endtask

   // Stops offering and waits until every owed result has been taken.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [30:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      apply_register_write(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_registers(input logic [30:0] stream_num, input logic client,
                                      input logic chunk, input logic [30:0] send_init,
                                      input logic [30:0] refill, input logic [30:0] low_mark);
      // Single-bit registers get random upper bits, which must be dropped.
      write_csr(CSR_STREAM_NUMBER, stream_num);
      write_csr(CSR_ROLE_CLIENT, {30'($urandom), client});
      write_csr(CSR_CHUNK_NOTICE, {30'($urandom), chunk});
      write_csr(CSR_SEND_WIN_INIT, send_init);
      write_csr(CSR_RECV_REFILL, refill);
      write_csr(CSR_RECV_LOW_MARK, low_mark);
   endtask

   // Idle stream: illegal sent frames, early received frames, window extremes.
   task automatic test_idle_stream();
      send_item(make_event(CMD_TX_HEADER, FT_PRIORITY, 8'h00, 32'd0, 32'd0));
      send_item(make_event(CMD_TX_HEADER, FT_DATA, FLAG_END_STREAM, 32'd0, 32'd0));
      send_item(make_event(CMD_TX_HEADER, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(make_event(CMD_RX_HEADER, FT_WINUPD, FLAG_HDRS_DONE, 32'd0, 32'd0));
      send_item(make_event(CMD_RX_HEADER, 8'hFF, 8'hFF, 32'd0, 32'd0));
      send_item(make_event(CMD_RX_DATA, FT_DATA, 8'h00, 32'd0, 32'd0));
      send_item(make_event(CMD_RX_DATA, FT_DATA, 8'h00, 32'hFFFF_FFFF, 32'd0));
      send_item(make_event(CMD_WIN_INC, FT_DATA, 8'h00, 32'd0, 32'h7FFF_FFFF));
      send_item(make_event(CMD_WIN_INC, FT_DATA, 8'h00, 32'd0, 32'h8000_0000));
      send_item(make_event(CMD_WIN_INC, FT_DATA, 8'h00, 32'd0, 32'hFFFF_FFFF));
   endtask

   // Register extremes, writes to spare indexes, and window wrap-around.
   task automatic test_register_extremes();
      wait_for_results();
      write_all_registers(31'h7FFF_FFFF, 1'b1, 1'b0, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                          31'h7FFF_FFFF);
      write_csr(CSR_SPARE_6, 31'($urandom));
      write_csr(CSR_SPARE_7, 31'($urandom));
      send_item(make_event(CMD_WIN_INC, FT_DATA, 8'h00, 32'd0, 32'd1));
      send_item(make_event(CMD_RX_DATA, FT_DATA, 8'h00, 32'd1, 32'd0));
      wait_for_results();
      write_all_registers(31'd0, 1'b0, 1'b1, 31'd0, 31'd0, 31'd0);
      send_item(make_event(CMD_RX_DATA, FT_DATA, 8'h00, 32'd5, 32'd0));
      send_item(make_event(CMD_WIN_INC, FT_DATA, 8'h00, 32'd0, 32'hFFFF_FFFF));
   endtask

   // Opening by a received HEADERS without the end-of-headers flag: goaway, yet the
   // stream opens.
   task automatic test_stream_opening();
      wait_for_results();
      write_all_registers(31'd2, 1'b0, 1'b1, 31'd65535, 31'd1000, 31'd500);
      send_item(make_event(CMD_RX_HEADER, FT_HEADERS, 8'h00, 32'd0, 32'd0));
      send_item(make_event(CMD_RX_HEADER, FT_PRIORITY, 8'h00, 32'd0, 32'd0));
      send_item(make_event(CMD_RX_HEADER, FT_CONT, 8'h00, 32'd0, 32'd0));
      send_item(make_event(CMD_RX_DATA, FT_DATA, 8'h00, 32'd600, 32'd0));
      send_item(make_event(CMD_RX_HEADER, FT_CONT, FLAG_HDRS_DONE, 32'd0, 32'd0));
      send_item(make_event(CMD_TX_HEADER, FT_DATA, 8'h00, 32'd0, 32'd0));
   endtask

   // One phase of random traffic under its own register setting.
   task automatic test_random_traffic(input int phase);
      int n;
      wait_for_results();
      case (phase)
         0: write_all_registers(31'($urandom), 1'($urandom), 1'b0, 31'($urandom),
                                31'h7FFF_FFFF, 31'h1FFF_FFFF);
         1: write_all_registers(31'd0, 1'b0, 1'b1, 31'd0, 31'd0, 31'd0);
         2: write_all_registers(31'h7FFF_FFFF, 1'b1, 1'($urandom), 31'h7FFF_FFFF,
                                31'd1000, 31'd900);
         default: write_all_registers(31'($urandom), 1'($urandom), 1'($urandom),
                                      31'($urandom), 31'($urandom), 31'($urandom));
      endcase
      quiet_mode = (phase == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
         send_item(random_event());
         random_sent++;
      end
      quiet_mode = 1'b0;
   endtask

   // The receiver holds off while events keep coming, then the sender waits for all results.
   task automatic test_receiver_backpressure();
      int n;
      quiet_mode = 1'b1;
      hold_requests++;
      for (n = 0; n < BURST_ITEMS; n++) begin
         send_item(random_event());
      end
      wait_for_results();
      quiet_mode = 1'b0;
   endtask

   // Drives the stream to closed, then checks what a closed stream still accepts.
   task automatic test_stream_closing();
      if (stream_now == ST_OPEN) begin
         send_item(make_event(CMD_RX_HEADER, FT_RST, FLAG_END_STREAM, 32'd0, 32'd0));
      end
      send_item(make_event(CMD_TX_HEADER, FT_RST, 8'h00, 32'd0, 32'd0));
      send_item(make_event(CMD_RX_HEADER, FT_PRIORITY, 8'h00, 32'd0, 32'd0));
      send_item(make_event(CMD_RX_HEADER, FT_HEADERS, 8'hFF, 32'd0, 32'd0));
      send_item(make_event(CMD_TX_HEADER, FT_HEADERS, FLAG_END_STREAM, 32'd0, 32'd0));
      send_item(make_event(CMD_RX_DATA, FT_DATA, 8'h00, 32'hFFFF_FFFF, 32'd0));
      send_item(make_event(CMD_WIN_INC, FT_DATA, 8'h00, 32'd0, 32'h7FFF_FFFF));
   endtask

   // Main sequence.
   initial begin
      int phase;
      int drain_cycles;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_RX_HEADER;
      req_chan.frame_type = FT_DATA;
      req_chan.frame_flags = 8'h00;
      req_chan.data_length = '0;
      req_chan.window_increment = '0;
      reset_tracker();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_idle_stream();
      test_register_extremes();
      test_stream_opening();
      for (phase = 0; phase < RANDOM_TOTAL / PHASE_ITEMS; phase++) begin
         test_random_traffic(phase);
      end
      test_receiver_backpressure();
      test_stream_closing();

      // Collect what is still owed, then let the pipeline settle.
      req_chan.valid <= 1'b0;
      drain_cycles = 0;
      do begin
         @(posedge clock);
         drain_cycles++;
      end while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT);
      repeat (4) @(posedge clock);
      if (pending_results.size() != 0) begin
         report_mismatch("missing results", pending_results.size(), 0);
      end
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Result receiver: random stalls, quiet stretches, and long hold-offs on request.
   initial begin
      int holds_done;
      int n;
      holds_done = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_chan.ready <= 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
         end
         rsp_chan.ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Each result transfer is compared with the oldest owed result.
   always @(posedge clock) begin : check_results
      stream_result_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_chan.status, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", rsp_chan.status, want.status);
            if (rsp_chan.stream_state !== want.state)
               report_mismatch("stream_state", rsp_chan.stream_state, want.state);
            if (rsp_chan.headers_done !== want.headers_done)
               report_mismatch("headers_done", rsp_chan.headers_done, want.headers_done);
            if (rsp_chan.deliver_message !== want.deliver)
               report_mismatch("deliver_message", rsp_chan.deliver_message, want.deliver);
            if (rsp_chan.message_is_response !== want.is_response)
               report_mismatch("message_is_response", rsp_chan.message_is_response,
                               want.is_response);
            if (rsp_chan.send_win_update !== want.win_update)
               report_mismatch("send_win_update", rsp_chan.send_win_update,
                               want.win_update);
            if (rsp_chan.update_increment !== want.update_incr)
               report_mismatch("update_increment", rsp_chan.update_increment,
                               want.update_incr);
            if (rsp_chan.send_window !== want.send_window)
               report_mismatch("send_window", rsp_chan.send_window, want.send_window);
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/h2st_pkg.sv
rtl/h2st_ifs.sv
rtl/http2_stream_state_tracker.sv
tb/sv/testbench.sv
